FILE: src/wbps_pkg.sv
// Shared constants, register codes and types of the wildcard byte pattern scanner.
package wbps_pkg;

    // Default parameter values of the top level.
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Fixed field widths.
    localparam int ADDR_W        = 48;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int SIG_W         = 128;
    localparam int CARE_W        = 16;
    localparam int LEN_REG_W     = 5;
    localparam int PATTERN_IDX_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_PATTERN_LEN  = 3'd3,
        CFG_REPORT_ALL   = 3'd4,
        CFG_BASE_ADDRESS = 3'd5
    } cfg_index_t;

    // Register settings as the scan logic sees them.
    typedef struct packed {
        logic [SIG_W-1:0]         signature;
        logic [CARE_W-1:0]        care_mask;
        logic [PATTERN_IDX_W-1:0] len_m1;
        logic                     report_all;
        logic [ADDR_W-1:0]        base_address;
    } cfg_t;

    // Status of the item held in the window stage.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_status_t;

endpackage

FILE: src/wbps_if.sv
// Valid/ready channel interfaces for image bytes and scan results.
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       last_byte;

    modport source (output valid, output image_byte, output last_byte, input ready);
    modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] match_address;
    logic        found;

    modport source (output valid, output match_address, output found, input ready);
    modport sink   (input valid, input match_address, input found, output ready);
endinterface

FILE: src/wbps_cfg.sv
// Configuration registers and the clamped pattern length.
module wbps_cfg #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wbps_pkg::cfg_t                   cfg
);
    import wbps_pkg::*;

    logic [63:0]           pattern_low_reg;
    logic [63:0]           pattern_high_reg;
    logic [CARE_W-1:0]     care_mask_reg;
    logic [LEN_REG_W-1:0]  pattern_len_reg;
    logic                  report_all_reg;
    logic [ADDR_W-1:0]     base_address_reg;
    logic [PATTERN_IDX_W-1:0] len_m1;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '1;
            pattern_len_reg  <= LEN_REG_W'(1);
            report_all_reg   <= 1'b0;
            base_address_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                CFG_CARE_MASK:    care_mask_reg    <= cfg_data[CARE_W-1:0];
                CFG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_REG_W-1:0];
                CFG_REPORT_ALL:   report_all_reg   <= cfg_data[0];
                CFG_BASE_ADDRESS: base_address_reg <= cfg_data[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    // A length of zero acts as one; lengths above the window depth act as the depth.
    always_comb
    begin
        if (pattern_len_reg == '0)
        begin
            len_m1 = '0;
        end
        else if (pattern_len_reg > LEN_REG_W'(PATTERN_MAX))
        begin
            len_m1 = PATTERN_IDX_W'(PATTERN_MAX - 1);
        end
        else
        begin
            len_m1 = PATTERN_IDX_W'(pattern_len_reg - LEN_REG_W'(1));
        end
    end

    assign cfg.signature    = {pattern_high_reg, pattern_low_reg};
    assign cfg.care_mask    = care_mask_reg;
    assign cfg.len_m1       = len_m1;
    assign cfg.report_all   = report_all_reg;
    assign cfg.base_address = base_address_reg;

endmodule

FILE: src/wbps_window.sv
// Input stage: byte window shift line, fill count and byte offset.
module wbps_window #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF,
    localparam int FILL_W     = $clog2(PATTERN_MAX + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    wbps_in_if.sink                              in_ch,
    input  logic [wbps_pkg::PATTERN_IDX_W-1:0]   len_m1,
    input  logic                                 take,
    output wbps_pkg::stage_status_t              status,
    output logic [PATTERN_MAX-1:0][7:0]          window,
    output logic [FILL_W-1:0]                    fill,
    output logic [OFFSET_BITS-1:0]               first_offset
);
    import wbps_pkg::*;

    logic [PATTERN_MAX-1:0][7:0] window_reg, window_next, window_base;
    logic [FILL_W-1:0]           fill_reg, fill_next, fill_base;
    logic [OFFSET_BITS-1:0]      offset_reg, offset_next, offset_base;
    logic [OFFSET_BITS-1:0]      first_reg, first_next;
    logic                        cleared_reg, cleared_next;
    logic                        valid_reg, valid_next;
    logic                        last_reg, last_next;
    logic                        accept;

    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;

    // Shift the new byte in; after the last byte of a scan start from a clear window.
    always_comb
    begin
        window_base  = cleared_reg ? '0 : window_reg;
        fill_base    = cleared_reg ? '0 : fill_reg;
        offset_base  = cleared_reg ? '0 : offset_reg;
        window_next  = window_reg;
        fill_next    = fill_reg;
        offset_next  = offset_reg;
        first_next   = first_reg;
        cleared_next = cleared_reg;
        last_next    = last_reg;
        valid_next   = valid_reg && !take;
        if (accept)
        begin
            window_next[0] = in_ch.image_byte;
            for (int k = 1; k < PATTERN_MAX; k++)
            begin
                window_next[k] = window_base[k-1];
            end
            fill_next    = (fill_base == FILL_W'(PATTERN_MAX)) ? fill_base
                                                               : fill_base + FILL_W'(1);
            first_next   = offset_base - OFFSET_BITS'(len_m1);
            offset_next  = offset_base + OFFSET_BITS'(1);
            cleared_next = in_ch.last_byte;
            last_next    = in_ch.last_byte;
            valid_next   = 1'b1;
        end
    end

    // Stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            fill_reg    <= '0;
            offset_reg  <= '0;
            cleared_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            offset_reg  <= offset_next;
            cleared_reg <= cleared_next;
            valid_reg   <= valid_next;
        end
    end

    // Payload of the held item.
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    assign status.valid  = valid_reg;
    assign status.last   = last_reg;
    assign window        = window_reg;
    assign fill          = fill_reg;
    assign first_offset  = first_reg;

endmodule

FILE: src/wbps_report.sv
// Result stage: wildcard compare of the window, match tracking and output register.
module wbps_report #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF,
    localparam int FILL_W     = $clog2(PATTERN_MAX + 1),
    localparam int WIN_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wbps_pkg::cfg_t              cfg,
    input  wbps_pkg::stage_status_t     status,
    input  logic [PATTERN_MAX-1:0][7:0] window,
    input  logic [FILL_W-1:0]           fill,
    input  logic [OFFSET_BITS-1:0]      first_offset,
    output logic                        take,
    wbps_out_if.source                  out_ch
);
    import wbps_pkg::*;

    logic [PATTERN_IDX_W-1:0] sel [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   byte_ok;
    logic                     hit;
    logic                     emit_match;
    logic                     emit_none;
    logic [ADDR_W-1:0]        match_addr;
    logic                     seen_reg, seen_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]        address_reg;
    logic                     found_reg;

    assign take = status.valid && (!out_valid_reg || out_ch.ready);

    // Signature byte i lines up with window entry len-1-i; bytes past the length pass.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            sel[i]     = cfg.len_m1 - PATTERN_IDX_W'(i);
            byte_ok[i] = (PATTERN_IDX_W'(i) > cfg.len_m1) || !cfg.care_mask[i] ||
                         (window[sel[i][WIN_IDX_W-1:0]] == cfg.signature[8*i +: 8]);
        end
        hit = (&byte_ok) && (LEN_REG_W'(fill) > {1'b0, cfg.len_m1});
    end

    // Result selection and match tracking across the scan.
    always_comb
    begin
        emit_match = hit && (cfg.report_all || !seen_reg);
        emit_none  = status.last && !hit && !seen_reg && !cfg.report_all;
        match_addr = cfg.base_address + ADDR_W'(first_offset);
        seen_next  = seen_reg;
        if (take)
        begin
            seen_next = status.last ? 1'b0 : (seen_reg || hit);
        end
        out_valid_next = take ? (emit_match || emit_none)
                              : (out_valid_reg && !out_ch.ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded only when a result is produced.
    always_ff @(posedge clk)
    begin
        if (take && (emit_match || emit_none))
        begin
            address_reg <= emit_match ? match_addr : '0;
            found_reg   <= emit_match;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.match_address = address_reg;
    assign out_ch.found         = found_reg;

endmodule

FILE: src/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner.
// The scanner takes one image byte per clock cycle and compares the most recent
// bytes against a signature of up to PATTERN_MAX bytes with per-byte wildcards,
// so overlapping matches are found. A byte passes through two register stages:
// the window stage shifts it in and updates the fill count and byte offset, and
// the result stage compares the whole window in parallel and loads the output
// register, from which the result is offered. The sustained rate is one byte per
// cycle, set by the combinational window compare, as long as the sink takes
// results when offered; a stalled result holds the window stage, which then takes
// a byte only while it is empty. The user must write the configuration only while
// the scanner is idle, which the block itself does not enforce; a match reports
// base_address plus the offset of its first byte, and in first-only mode a scan
// without a match ends in a not-found result.
module wildcard_byte_pattern_scanner_top #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    wbps_in_if.sink                          in_ch,
    wbps_out_if.source                       out_ch
);
    import wbps_pkg::*;

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);

    cfg_t                        cfg;
    stage_status_t               status;
    logic [PATTERN_MAX-1:0][7:0] window;
    logic [FILL_W-1:0]           fill;
    logic [OFFSET_BITS-1:0]      first_offset;
    logic                        take;

    // Configuration registers.
    wbps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window stage.
    wbps_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .len_m1       (cfg.len_m1),
        .take         (take),
        .status       (status),
        .window       (window),
        .fill         (fill),
        .first_offset (first_offset)
    );

    // Compare and result stage.
    wbps_report #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .status       (status),
        .window       (window),
        .fill         (fill),
        .first_offset (first_offset),
        .take         (take),
        .out_ch       (out_ch)
    );

endmodule

FILE: bench/scan_result_checker.sv
// Checker that predicts the scanner results from observed traffic and compares them.
module scan_result_checker
    import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    wbps_in_if                     in_mon,
    wbps_out_if                    out_mon,
    output int                     mismatches,
    output int                     outstanding
);
    localparam int OFS_W     = OFFSET_BITS_DEF;
    localparam int WIN_DEPTH = PATTERN_MAX_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              found;
    } scan_result_t;

    // Register copies.
    logic [SIG_W-1:0]     sig_bytes;
    logic [CARE_W-1:0]    care_bits;
    logic [LEN_REG_W-1:0] len_reg;
    logic                 all_mode;
    logic [ADDR_W-1:0]    base_addr;

    // Scan state.
    logic [7:0]       window [WIN_DEPTH];
    int               fill;
    logic [OFS_W-1:0] next_offset;
    logic             hit_seen;

    scan_result_t expected_hits [$];
    int           error_count = 0;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        error_count = error_count + 1;
        mismatches  = error_count;
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic clear_scan();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            window[i] = 8'h00;
        end
        fill        = 0;
        next_offset = '0;
        hit_seen    = 1'b0;
    endtask

    // Pattern length register as the scan uses it.
    function automatic int effective_length(input logic [LEN_REG_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > WIN_DEPTH)
            return WIN_DEPTH;
        return int'(r);
    endfunction

    // Advances the scan state by one image byte and queues the result it causes.
    task automatic scan_next_byte(input logic [7:0] b, input logic last);
        int               n;
        logic             hit;
        logic             reported;
        logic [OFS_W-1:0] cur;
        logic [OFS_W-1:0] first;
        scan_result_t     r;

        n        = effective_length(len_reg);
        cur      = next_offset;
        reported = 1'b0;

        for (int i = WIN_DEPTH - 1; i > 0; i--)
        begin
            window[i] = window[i-1];
        end
        window[0] = b;
        if (fill < WIN_DEPTH)
            fill = fill + 1;

        // The oldest of the last n window bytes lines up with signature byte zero.
        hit = (fill >= n);
        for (int i = 0; i < n; i++)
        begin
            if (care_bits[i] && window[n-1-i] != sig_bytes[8*i +: 8])
                hit = 1'b0;
        end

        if (hit && (all_mode || !hit_seen))
        begin
            first     = cur - OFS_W'(n - 1);
            r.address = base_addr + {{(ADDR_W-OFS_W){1'b0}}, first};
            r.found   = 1'b1;
            expected_hits = {expected_hits, r};
            reported  = 1'b1;
        end
        if (hit)
            hit_seen = 1'b1;
        next_offset = cur + 1'b1;

        // End of image: a first-only scan without any match reports not-found.
        if (last)
        begin
            if (!reported && !hit_seen && !all_mode)
            begin
                r.address = '0;
                r.found   = 1'b0;
                expected_hits = {expected_hits, r};
            end
            clear_scan();
        end
    endtask

    // Monitor: register writes, accepted image bytes and accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_bytes = '0;
            care_bits = '1;
            len_reg   = 5'd1;
            all_mode  = 1'b0;
            base_addr = '0;
            clear_scan();
            expected_hits.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_LOW:  sig_bytes[63:0]   = cfg_data;
                    CFG_PATTERN_HIGH: sig_bytes[127:64] = cfg_data;
                    CFG_CARE_MASK:    care_bits         = cfg_data[CARE_W-1:0];
                    CFG_PATTERN_LEN:  len_reg           = cfg_data[LEN_REG_W-1:0];
                    CFG_REPORT_ALL:   all_mode          = cfg_data[0];
                    CFG_BASE_ADDRESS: base_addr         = cfg_data[ADDR_W-1:0];
                    default:          ;
                endcase
            end

            if (in_mon.valid && in_mon.ready)
                scan_next_byte(in_mon.image_byte, in_mon.last_byte);

            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("result with nothing pending", out_mon.match_address, '0);
                end
                else
                begin
                    scan_result_t want;
                    want = expected_hits.pop_front();
                    if (out_mon.match_address !== want.address)
                        report_mismatch("match_address", out_mon.match_address, want.address);
                    if (out_mon.found !== want.found)
                        report_mismatch("found", ADDR_W'(out_mon.found),
                                        ADDR_W'(want.found));
                end
            end
            outstanding = expected_hits.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Top of the scanner testbench: clock, reset, stimulus, result sink and verdict.
module tb_top;
    import wbps_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 21;
    localparam int RANDOM_PHASES = 16;
    localparam int DRAIN_CYCLES  = 6;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_asked;

    // Register settings as the stimulus knows them, used to embed signatures.
    logic [SIG_W-1:0]     cur_sig;
    logic [CARE_W-1:0]    cur_care;
    logic [LEN_REG_W-1:0] cur_len;

    logic [7:0] img [64];

    wbps_in_if  in_ch ();
    wbps_out_if out_ch ();

    wildcard_byte_pattern_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    scan_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Watchdog.
    initial
    begin
        #3000000;
        $display("wildcard_byte_pattern_scanner_top verification failed");
        $finish;
    end

    // Result sink: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_served;
        hold_served  = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                out_ch.ready <= 1'b0;
                for (int k = 1; k < HOLD_CYCLES; k++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offers one image byte and returns at the edge where the transaction completes.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.image_byte <= b;
        in_ch.last_byte  <= last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] care, input logic [4:0] len,
                              input logic all, input logic [47:0] base);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_CARE_MASK, {48'd0, care});
        write_reg(CFG_PATTERN_LEN, {59'd0, len});
        write_reg(CFG_REPORT_ALL, {63'd0, all});
        write_reg(CFG_BASE_ADDRESS, {16'd0, base});
        cfg_write <= 1'b0;
        cur_sig  = {hi, lo};
        cur_care = care;
        cur_len  = len;
    endtask

    // Stops offering bytes and waits until the scanner has delivered everything.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Builds one image with embedded, sometimes corrupted, signatures and sends it.
    task automatic run_scan(output int sent);
        int n_used;
        int len;
        int ins;
        int p;
        int k;

        n_used = (cur_len == 0) ? 1 : ((cur_len > 16) ? 16 : int'(cur_len));
        if ($urandom_range(3) == 0)
            len = $urandom_range(40, n_used);
        else
            len = $urandom_range(n_used + 6, 1);

        // Noise drawn half from the signature bytes, half from the whole byte range.
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1) == 1)
                img[i] = cur_sig[8*$urandom_range(n_used - 1) +: 8];
            else
                img[i] = 8'($urandom_range(255));
        end

        ins = ($urandom_range(9) < 7) ? $urandom_range(2, 1) : 0;
        for (int m = 0; m < ins; m++)
        begin
            if (len >= n_used)
            begin
                p = $urandom_range(len - n_used);
                for (int j = 0; j < n_used; j++)
                begin
                    img[p+j] = cur_care[j] ? cur_sig[8*j +: 8] : 8'($urandom_range(255));
                end
                if ($urandom_range(4) == 0)
                begin
                    k = p + $urandom_range(n_used - 1);
                    img[k] = img[k] ^ (8'h01 << $urandom_range(7));
                end
            end
        end

        for (int i = 0; i < len; i++)
        begin
            send_byte(img[i], i == len - 1);
        end
        sent = len;
    endtask

    task automatic random_config(input int ph);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] r64;
        logic [15:0] care;
        logic [4:0]  len;
        logic [47:0] base;

        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if (ph % 5 == 0)
            len = 5'd16;
        else if (ph == 7)
            len = 5'd20;
        else
            len = 5'($urandom_range(8, 1));
        if (ph % 7 == 3)
            care = 16'h0000;
        else if (ph % 3 == 0)
            care = 16'hFFFF;
        else
            care = 16'($urandom_range(16'hFFFF));
        if (ph % 4 == 1)
        begin
            base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(20));
        end
        else
        begin
            r64  = {$urandom, $urandom};
            base = r64[47:0];
        end
        set_config(lo, hi, care, len, 1'($urandom_range(1)), base);
    endtask

    // Main stimulus.
    initial
    begin
        int got;
        int count;
        int guard;

        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.image_byte = 8'h00;
        in_ch.last_byte  = 1'b0;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        hold_asked       = 0;
        cur_sig          = '0;
        cur_care         = 16'hFFFF;
        cur_len          = 5'd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: single zero byte signature, first-only mode,
        // then a scan without a match and a match on the last byte.
        // The sink holds off meanwhile, so the first match backs up the input.
        hold_asked = hold_asked + 1;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        settle();

        // Overlapping matches in all mode with the address wrapping past the top;
        // no result at the end of an all-mode scan.
        set_config(64'h0000_0000_0000_AAAA, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd2,
                   1'b1, 48'hFFFF_FFFF_FFFF);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Zero length taken as one, every byte a wildcard.
        set_config(64'd0, 64'd0, 16'h0000, 5'd0, 1'b0, 48'd0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b1);
        settle();

        // Length beyond the maximum clamps to sixteen; upper half wildcards;
        // the match completes on the last byte.
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'h00FF, 5'd31, 1'b0,
                   48'h1234_5678_9ABC);
        for (int i = 0; i < 16; i++)
        begin
            send_byte((i < 8) ? 8'hFF : 8'($urandom_range(255)), i == 15);
        end
        settle();

        // Random phases across settings and idling modes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_config(ph);
            case (ph % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 69;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 69;
                end
                default:
                begin
                    tx_idle_pct  = 22;
                    rx_stall_pct = 22;
                end
            endcase
            // Long sink hold-off while bytes keep coming, so the input backs up.
            if (ph == 0)
                hold_asked = hold_asked + 1;
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                run_scan(got);
                count = count + got;
            end
            settle();
        end

        guard = 0;
        while (outstanding != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard = guard + 1;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("wildcard_byte_pattern_scanner_top verification clean");
        else
            $display("wildcard_byte_pattern_scanner_top verification failed");
        $finish;
    end

endmodule
